FILE: hdl/ocq_pkg.sv
`timescale 1ns / 1ps

package ocq_pkg;

    localparam int RAW_W   = 16;
    localparam int LSB_W   = 10;
    localparam int CNT_W   = 8;
    localparam int PROD_W  = RAW_W + LSB_W;
    localparam int FULL_W  = 2 * PROD_W;
    localparam int QUOT_W  = 16;

    // q = (p * RECIP) >> RECIP_SHIFT equals p / 1000 for every p below 2^25
    localparam int                RECIP_SHIFT = 35;
    localparam logic [PROD_W-1:0] RECIP       = 26'd34359739;

    localparam logic [QUOT_W-1:0]       POS_MAX   = 16'd32767;
    localparam logic [QUOT_W-1:0]       NEG_MAX   = 16'd32768;
    localparam logic signed [RAW_W-1:0] MA_MAX    = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] MA_MIN    = 16'sh8000;
    localparam logic [CNT_W-1:0]        CNT_MAX   = 8'd255;

    localparam logic [1:0] REG_LSB   = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_TRIP  = 2'd2;
    localparam logic [1:0] REG_CLEAR = 2'd3;

    localparam logic [LSB_W-1:0]        RST_LSB   = 10'd100;
    localparam logic signed [RAW_W-1:0] RST_LIMIT = 16'sd1000;
    localparam logic [CNT_W-1:0]        RST_TRIP  = 8'd3;
    localparam logic [CNT_W-1:0]        RST_CLEAR = 8'd10;

    typedef struct packed {
        logic [LSB_W-1:0]        current_lsb_ua;
        logic signed [RAW_W-1:0] over_limit_ma;
        logic [CNT_W-1:0]        trip_polls;
        logic [CNT_W-1:0]        clear_polls;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic              neg;
        logic [QUOT_W-1:0] mag;
    } quot_t;

endpackage

FILE: hdl/ocq_poll_if.sv
`timescale 1ns / 1ps

interface ocq_poll_if;
    logic                                valid;
    logic                                ready;
    logic signed [ocq_pkg::RAW_W-1:0]    raw_current;
    logic                                read_ok;

    modport source (output valid, output raw_current, output read_ok, input ready);
    modport sink (input valid, input raw_current, input read_ok, output ready);
endinterface

FILE: hdl/ocq_status_if.sv
`timescale 1ns / 1ps

interface ocq_status_if;
    logic                                valid;
    logic                                ready;
    logic signed [ocq_pkg::RAW_W-1:0]    load_ma;
    logic                                over_limit;
    logic                                fault_active;
    logic                                trip_pulse;

    modport source (output valid, output load_ma, output over_limit,
                    output fault_active, output trip_pulse, input ready);
    modport sink (input valid, input load_ma, input over_limit,
                  input fault_active, input trip_pulse, output ready);
endinterface

FILE: hdl/ocq_cfg_regs.sv
`timescale 1ns / 1ps

module ocq_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ocq_pkg::cfg_t     cfg
);

    ocq_pkg::cfg_t cfg_reg;
    ocq_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                ocq_pkg::REG_LSB:   cfg_next.current_lsb_ua = pwdata[ocq_pkg::LSB_W-1:0];
                ocq_pkg::REG_LIMIT: cfg_next.over_limit_ma  = $signed(pwdata[ocq_pkg::RAW_W-1:0]);
                ocq_pkg::REG_TRIP:  cfg_next.trip_polls     = pwdata[ocq_pkg::CNT_W-1:0];
                ocq_pkg::REG_CLEAR: cfg_next.clear_polls    = pwdata[ocq_pkg::CNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_lsb_ua <= ocq_pkg::RST_LSB;
            cfg_reg.over_limit_ma  <= ocq_pkg::RST_LIMIT;
            cfg_reg.trip_polls     <= ocq_pkg::RST_TRIP;
            cfg_reg.clear_polls    <= ocq_pkg::RST_CLEAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            ocq_pkg::REG_LSB:   prdata = {22'd0, cfg_reg.current_lsb_ua};
            ocq_pkg::REG_LIMIT: prdata = {{16{cfg_reg.over_limit_ma[ocq_pkg::RAW_W-1]}},
                                          cfg_reg.over_limit_ma};
            ocq_pkg::REG_TRIP:  prdata = {24'd0, cfg_reg.trip_polls};
            ocq_pkg::REG_CLEAR: prdata = {24'd0, cfg_reg.clear_polls};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/ocq_scale.sv
`timescale 1ns / 1ps

module ocq_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [ocq_pkg::RAW_W-1:0] raw_current,
    input  logic                             read_ok,
    input  logic [ocq_pkg::LSB_W-1:0]        current_lsb_ua,
    output ocq_pkg::quot_t                   quot,
    input  logic                             quot_take
);

    // stage 1: input register
    logic                         s1_valid_reg, s1_valid_next;
    logic signed [ocq_pkg::RAW_W-1:0] s1_raw_reg;
    logic                         s1_ok_reg;
    // stage 2: |raw| * lsb
    logic                         s2_valid_reg, s2_valid_next;
    logic                         s2_ok_reg, s2_neg_reg;
    logic [ocq_pkg::PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    // stage 3: divide by 1000 via reciprocal
    logic                         s3_valid_reg, s3_valid_next;
    logic                         s3_ok_reg, s3_neg_reg;
    logic [ocq_pkg::QUOT_W-1:0]   s3_mag_reg, s3_mag_next;

    logic                         ld1, ld2, ld3;
    logic [ocq_pkg::RAW_W-1:0]    abs_raw;
    logic [ocq_pkg::FULL_W-1:0]   full_prod;

    assign ld3      = !s3_valid_reg || quot_take;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_ready = ld1;

    assign s1_valid_next = ld1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = ld2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = ld3 ? s2_valid_reg : s3_valid_reg;

    assign abs_raw      = s1_raw_reg[ocq_pkg::RAW_W-1] ? (~s1_raw_reg + 1'b1) : s1_raw_reg;
    assign s2_prod_next = {{ocq_pkg::LSB_W{1'b0}}, abs_raw}
                        * {{ocq_pkg::RAW_W{1'b0}}, current_lsb_ua};

    assign full_prod    = {{ocq_pkg::PROD_W{1'b0}}, s2_prod_reg}
                        * {{ocq_pkg::PROD_W{1'b0}}, ocq_pkg::RECIP};
    assign s3_mag_next  = full_prod[ocq_pkg::QUOT_W+ocq_pkg::RECIP_SHIFT-1:ocq_pkg::RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            s1_raw_reg <= raw_current;
            s1_ok_reg  <= read_ok;
        end
        if (ld2 && s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_ok_reg   <= s1_ok_reg;
            s2_neg_reg  <= s1_raw_reg[ocq_pkg::RAW_W-1];
        end
        if (ld3 && s2_valid_reg)
        begin
            s3_mag_reg <= s3_mag_next;
            s3_ok_reg  <= s2_ok_reg;
            s3_neg_reg <= s2_neg_reg;
        end
    end

    assign quot.valid = s3_valid_reg;
    assign quot.ok    = s3_ok_reg;
    assign quot.neg   = s3_neg_reg;
    assign quot.mag   = s3_mag_reg;

endmodule

FILE: hdl/ocq_qualify.sv
`timescale 1ns / 1ps

module ocq_qualify (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ocq_pkg::quot_t                    quot,
    output logic                              quot_take,
    input  ocq_pkg::cfg_t                     cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ocq_pkg::RAW_W-1:0]  load_ma,
    output logic                              over_limit,
    output logic                              fault_active,
    output logic                              trip_pulse
);

    logic                             out_valid_reg, out_valid_next;
    logic [ocq_pkg::CNT_W-1:0]        over_run_reg, over_run_next;
    logic [ocq_pkg::CNT_W-1:0]        stable_run_reg, stable_run_next;
    logic                             fault_reg, fault_next;
    logic signed [ocq_pkg::RAW_W-1:0] ma_reg, ma_next;
    logic                             over_reg, over_next;
    logic                             pulse_reg, pulse_next;

    logic signed [ocq_pkg::RAW_W-1:0] sat_ma;
    logic [ocq_pkg::CNT_W-1:0]        over_inc, stable_inc;

    assign quot_take      = quot.valid && (!out_valid_reg || out_ready);
    assign out_valid_next = quot_take ? 1'b1 : (out_valid_reg && !out_ready);

    always_comb
    begin
        if (quot.neg)
        begin
            if (quot.mag > ocq_pkg::NEG_MAX)
                sat_ma = ocq_pkg::MA_MIN;
            else
                sat_ma = $signed(~quot.mag + 1'b1);
        end
        else
        begin
            if (quot.mag > ocq_pkg::POS_MAX)
                sat_ma = ocq_pkg::MA_MAX;
            else
                sat_ma = $signed(quot.mag);
        end
    end

    assign over_inc   = (over_run_reg == ocq_pkg::CNT_MAX) ? over_run_reg : over_run_reg + 1'b1;
    assign stable_inc = (stable_run_reg == ocq_pkg::CNT_MAX) ? stable_run_reg
                                                               : stable_run_reg + 1'b1;

    always_comb
    begin
        over_run_next   = over_run_reg;
        stable_run_next = stable_run_reg;
        fault_next      = fault_reg;
        ma_next         = '0;
        over_next       = 1'b0;
        pulse_next      = 1'b0;
        if (!quot.ok)
        begin
            over_run_next = '0;
        end
        else
        begin
            ma_next = sat_ma;
            if (sat_ma > cfg.over_limit_ma)
            begin
                over_next       = 1'b1;
                stable_run_next = '0;
                over_run_next   = over_inc;
                if (over_inc >= cfg.trip_polls)
                begin
                    fault_next = 1'b1;
                    pulse_next = 1'b1;
                end
            end
            else
            begin
                over_run_next   = '0;
                stable_run_next = stable_inc;
                if (stable_inc >= cfg.clear_polls)
                begin
                    fault_next      = 1'b0;
                    stable_run_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            over_run_reg   <= '0;
            stable_run_reg <= '0;
            fault_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (quot_take)
            begin
                over_run_reg   <= over_run_next;
                stable_run_reg <= stable_run_next;
                fault_reg      <= fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot_take)
        begin
            ma_reg    <= ma_next;
            over_reg  <= over_next;
            pulse_reg <= pulse_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign load_ma      = ma_reg;
    assign over_limit   = over_reg;
    assign fault_active = fault_reg;
    assign trip_pulse   = pulse_reg;

endmodule

FILE: hdl/overcurrent_trip_qualifier_core.sv
`timescale 1ns / 1ps
// Over-current trip qualifier.
// poll (sink): one sensor poll per request, raw_current and read_ok.
// status (source): one result per poll: load_ma, over_limit,
//   fault_active and trip_pulse, in poll order.
// APB port: current_lsb_ua at 0x0, over_limit_ma at 0x4, trip_polls at
//   0x8, clear_polls at 0xC; write only while no poll is in flight.
// Path: input register, |raw| * lsb product, reciprocal divide by 1000,
//   then saturate/compare/count into the result register.
// Throughput: one poll per cycle while the status sink takes results;
//   the run counters and fault flag update in the last stage, so
//   consecutive polls never wait on each other.
// A stalled status sink holds the result register; the three stages in
//   front keep filling, so up to four polls are taken before poll.ready
//   drops.
// Reset: pipeline emptied, run counts zero, fault clear, registers at
//   their defaults (100 uA, 1000 mA, 3 polls, 10 polls).

module overcurrent_trip_qualifier_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    ocq_poll_if.sink            poll,
    ocq_status_if.source        status
);

    ocq_pkg::cfg_t  cfg;
    ocq_pkg::quot_t quot;
    logic           quot_take;

    ocq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ocq_scale u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (poll.valid),
        .in_ready       (poll.ready),
        .raw_current    (poll.raw_current),
        .read_ok        (poll.read_ok),
        .current_lsb_ua (cfg.current_lsb_ua),
        .quot           (quot),
        .quot_take      (quot_take)
    );

    ocq_qualify u_qualify (
        .clk          (clk),
        .rst_n        (rst_n),
        .quot         (quot),
        .quot_take    (quot_take),
        .cfg          (cfg),
        .out_valid    (status.valid),
        .out_ready    (status.ready),
        .load_ma      (status.load_ma),
        .over_limit   (status.over_limit),
        .fault_active (status.fault_active),
        .trip_pulse   (status.trip_pulse)
    );

endmodule

FILE: bench/tb_overcurrent_trip_qualifier_core.sv
`timescale 1ns / 1ps

module tb_overcurrent_trip_qualifier_core;

    localparam int RAW_W          = ocq_pkg::RAW_W;
    localparam int LSB_W          = ocq_pkg::LSB_W;
    localparam int CNT_W          = ocq_pkg::CNT_W;
    localparam int UA_PER_MA      = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic signed [RAW_W-1:0] load_ma;
        logic                    over_limit;
        logic                    fault_active;
        logic                    trip_pulse;
    } poll_status_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic                    ok;
        logic                    typed;
        poll_status_t            want;
    } directed_row_t;

    localparam poll_status_t NO_STATUS = '0;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ocq_poll_if   poll_ch();
    ocq_status_if status_ch();

    overcurrent_trip_qualifier_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .poll    (poll_ch),
        .status  (status_ch)
    );

    // qualifier model state
    ocq_pkg::cfg_t    qual_cfg;
    logic [CNT_W-1:0] over_run;
    logic [CNT_W-1:0] stable_run;
    logic             fault_latched;

    poll_status_t  pending_status[$];
    directed_row_t directed_rows[DIRECTED_ROWS];

    int mismatches    = 0;
    int idle_cycles   = 0;
    int tx_idle_max   = 8;
    int rx_idle_max   = 8;
    int rx_hold_cycles = 0;
    int fail_pct      = 5;

    poll_status_t got_status;
    poll_status_t want_status;

    always #10 clk = ~clk;

    function automatic logic signed [RAW_W-1:0] scale_ma(logic signed [RAW_W-1:0] raw,
                                                         logic [LSB_W-1:0] lsb);
        int ua;
        int ma;
        ua = int'(raw) * int'(lsb);
        ma = ua / UA_PER_MA;
        if (ma > int'(ocq_pkg::MA_MAX))
            ma = int'(ocq_pkg::MA_MAX);
        if (ma < int'(ocq_pkg::MA_MIN))
            ma = int'(ocq_pkg::MA_MIN);
        return RAW_W'(ma);
    endfunction

    function automatic poll_status_t qualify_poll(logic signed [RAW_W-1:0] raw, logic ok);
        poll_status_t res;
        res = '0;
        if (!ok)
        begin
            over_run = '0;
        end
        else
        begin
            res.load_ma = scale_ma(raw, qual_cfg.current_lsb_ua);
            if ($signed(res.load_ma) > $signed(qual_cfg.over_limit_ma))
            begin
                res.over_limit = 1'b1;
                stable_run = '0;
                if (over_run < ocq_pkg::CNT_MAX)
                    over_run = over_run + 1'b1;
                if (over_run >= qual_cfg.trip_polls)
                begin
                    fault_latched = 1'b1;
                    res.trip_pulse = 1'b1;
                end
            end
            else
            begin
                over_run = '0;
                if (stable_run < ocq_pkg::CNT_MAX)
                    stable_run = stable_run + 1'b1;
                if (stable_run >= qual_cfg.clear_polls)
                begin
                    fault_latched = 1'b0;
                    stable_run = '0;
                end
            end
        end
        res.fault_active = fault_latched;
        return res;
    endfunction

    // raw reading on the wanted side of the threshold, when one is found
    function automatic logic signed [RAW_W-1:0] pick_raw(bit want_over);
        logic signed [RAW_W-1:0] cand;
        int base;
        int off;
        int span;
        int tries;
        cand = '0;
        base = 0;
        if (qual_cfg.current_lsb_ua != '0)
            base = int'($signed(qual_cfg.over_limit_ma)) * UA_PER_MA
                   / int'(qual_cfg.current_lsb_ua);
        for (tries = 0; tries < 16; tries++)
        begin
            case ($urandom_range(0, 2))
                0: cand = RAW_W'($urandom);
                1:
                begin
                    off = base + int'($urandom_range(0, 64)) - 32;
                    if (off > int'(ocq_pkg::MA_MAX))
                        off = int'(ocq_pkg::MA_MAX);
                    if (off < int'(ocq_pkg::MA_MIN))
                        off = int'(ocq_pkg::MA_MIN);
                    cand = RAW_W'(off);
                end
                default:
                begin
                    span = 1 << $urandom_range(0, 15);
                    off = int'($urandom_range(0, 2 * span)) - span;
                    cand = RAW_W'(off);
                end
            endcase
            if (($signed(scale_ma(cand, qual_cfg.current_lsb_ua))
                 > $signed(qual_cfg.over_limit_ma)) == want_over)
                return cand;
        end
        return cand;
    endfunction

    task automatic apb_write_reg(logic [1:0] idx, int value);
        logic [31:0] mask;
        case (idx)
            ocq_pkg::REG_LSB:   mask = (32'd1 << LSB_W) - 1;
            ocq_pkg::REG_LIMIT: mask = (32'd1 << RAW_W) - 1;
            default:            mask = (32'd1 << CNT_W) - 1;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((prdata & mask) !== (32'(value) & mask))
        begin
            $error("reg %0d readback: expected %h, got %h", idx, 32'(value) & mask,
                   prdata & mask);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            ocq_pkg::REG_LSB:   qual_cfg.current_lsb_ua = LSB_W'(value);
            ocq_pkg::REG_LIMIT: qual_cfg.over_limit_ma  = RAW_W'(value);
            ocq_pkg::REG_TRIP:  qual_cfg.trip_polls     = CNT_W'(value);
            default:            qual_cfg.clear_polls    = CNT_W'(value);
        endcase
    endtask

    task automatic send_poll(logic signed [RAW_W-1:0] raw, logic ok, logic typed,
                             poll_status_t typed_want);
        int gap;
        poll_status_t predicted;
        gap = $urandom_range(0, tx_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        poll_ch.valid       <= 1'b1;
        poll_ch.raw_current <= raw;
        poll_ch.read_ok     <= ok;
        @(posedge clk);
        while (!poll_ch.ready)
            @(posedge clk);
        predicted = qualify_poll(raw, ok);
        pending_status.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain_polls();
        @(negedge clk);
        poll_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // runs of over-current or in-limit polls, with short runs and failed reads mixed in
    task automatic run_phase(int lsb, int limit, int trip, int clear, int n_polls,
                             int idle_max, int fail_rate, int hold);
        int sent;
        int len;
        int span;
        int k;
        bit want_over;
        logic signed [RAW_W-1:0] raw;
        logic ok;
        drain_polls();
        apb_write_reg(ocq_pkg::REG_LSB, lsb);
        apb_write_reg(ocq_pkg::REG_LIMIT, limit);
        apb_write_reg(ocq_pkg::REG_TRIP, trip);
        apb_write_reg(ocq_pkg::REG_CLEAR, clear);
        tx_idle_max    = idle_max;
        rx_idle_max    = idle_max;
        fail_pct       = fail_rate;
        rx_hold_cycles = hold;
        sent = 0;
        while (sent < n_polls)
        begin
            want_over = 1'($urandom_range(0, 1));
            span = want_over ? int'(qual_cfg.trip_polls) : int'(qual_cfg.clear_polls);
            case ($urandom_range(0, 5))
                0:       len = $urandom_range(1, 3);
                1, 2:    len = span + int'($urandom_range(0, 4));
                default: len = $urandom_range(1, span + 2);
            endcase
            for (k = 0; k < len && sent < n_polls; k++)
            begin
                ok = ($urandom_range(0, 99) >= fail_pct);
                if ($urandom_range(0, 11) == 0)
                    raw = RAW_W'($urandom);
                else
                    raw = pick_raw(want_over);
                send_poll(raw, ok, 1'b0, NO_STATUS);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if ((poll_ch.valid && poll_ch.ready) || (status_ch.valid && status_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[overcurrent_trip_qualifier_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            got_status.load_ma      = status_ch.load_ma;
            got_status.over_limit   = status_ch.over_limit;
            got_status.fault_active = status_ch.fault_active;
            got_status.trip_pulse   = status_ch.trip_pulse;
            if (pending_status.size() == 0)
            begin
                $error("status with no poll pending");
                mismatches++;
            end
            else
            begin
                want_status = pending_status.pop_front();
                if (got_status.load_ma !== want_status.load_ma)
                begin
                    $error("load_ma: expected %0d, got %0d",
                           $signed(want_status.load_ma), $signed(got_status.load_ma));
                    mismatches++;
                end
                if (got_status.over_limit !== want_status.over_limit)
                begin
                    $error("over_limit: expected %0d, got %0d",
                           want_status.over_limit, got_status.over_limit);
                    mismatches++;
                end
                if (got_status.fault_active !== want_status.fault_active)
                begin
                    $error("fault_active: expected %0d, got %0d",
                           want_status.fault_active, got_status.fault_active);
                    mismatches++;
                end
                if (got_status.trip_pulse !== want_status.trip_pulse)
                begin
                    $error("trip_pulse: expected %0d, got %0d",
                           want_status.trip_pulse, got_status.trip_pulse);
                    mismatches++;
                end
            end
        end
    end

    // status sink: random stall per request, long hold when asked
    initial
    begin
        int stall;
        status_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                stall = $urandom_range(0, rx_idle_max);
            end
            if (stall > 0)
            begin
                status_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            status_ch.ready <= 1'b1;
            @(posedge clk);
            while (!status_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int i;
        int p;
        int lsb_r;
        int limit_r;
        int trip_r;
        int clear_r;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        poll_ch.valid       = 1'b0;
        poll_ch.raw_current = '0;
        poll_ch.read_ok     = 1'b0;
        qual_cfg            = '{ocq_pkg::RST_LSB, ocq_pkg::RST_LIMIT, ocq_pkg::RST_TRIP,
                                ocq_pkg::RST_CLEAR};
        over_run            = '0;
        stable_run          = '0;
        fault_latched       = 1'b0;

        // default config: 100 uA per count, 1000 mA limit, trip 3, clear 10
        directed_rows = '{
            '{16'sd0,      1'b1, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
            '{16'sh7FFF,   1'b1, 1'b1, '{16'sd3276,  1'b1, 1'b0, 1'b0}},
            '{16'sh8000,   1'b1, 1'b1, '{-16'sd3276, 1'b0, 1'b0, 1'b0}},
            '{16'sh7FFF,   1'b1, 1'b0, NO_STATUS},
            '{16'sd0,      1'b0, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
            '{16'sh7FFF,   1'b1, 1'b0, NO_STATUS},
            '{16'sh7FFF,   1'b1, 1'b0, NO_STATUS},
            '{16'sh7FFF,   1'b1, 1'b1, '{16'sd3276,  1'b1, 1'b1, 1'b1}},
            '{16'sh7FFF,   1'b1, 1'b1, '{16'sd3276,  1'b1, 1'b1, 1'b1}},
            '{16'shFFFF,   1'b0, 1'b1, '{16'sd0,     1'b0, 1'b1, 1'b0}},
            '{16'sd10010,  1'b1, 1'b0, NO_STATUS},
            '{16'sd10009,  1'b1, 1'b0, NO_STATUS},
            '{-16'sd9,     1'b1, 1'b0, NO_STATUS},
            '{-16'sd10,    1'b1, 1'b0, NO_STATUS},
            '{16'sh8000,   1'b0, 1'b0, NO_STATUS},
            '{16'sd9,      1'b1, 1'b0, NO_STATUS},
            '{16'sd19,     1'b1, 1'b0, NO_STATUS},
            '{-16'sd19,    1'b1, 1'b0, NO_STATUS},
            '{16'sd1,      1'b1, 1'b0, NO_STATUS},
            '{-16'sd1,     1'b1, 1'b0, NO_STATUS},
            '{16'sd100,    1'b1, 1'b0, NO_STATUS},
            '{16'sd2730,   1'b1, 1'b0, NO_STATUS},
            '{16'sh5555,   1'b1, 1'b0, NO_STATUS},
            '{16'shAAAA,   1'b1, 1'b0, NO_STATUS}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_poll(directed_rows[i].raw, directed_rows[i].ok, directed_rows[i].typed,
                      directed_rows[i].want);

        run_phase(1000, 0, 1, 1, 110, 8, 5, 0);
        // limit at the floor with maximum counts: run count saturates
        run_phase(1023, -32768, 255, 255, 520, 8, 0, 0);
        run_phase(0, -1, 0, 0, 110, 0, 5, 0);
        run_phase(1, 32767, 2, 255, 110, 8, 5, 0);

        for (p = 0; p < 5; p++)
        begin
            lsb_r   = $urandom_range(0, 1023);
            limit_r = int'($signed(scale_ma(RAW_W'($urandom), LSB_W'(lsb_r))));
            trip_r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6);
            clear_r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6);
            run_phase(lsb_r, limit_r, trip_r, clear_r, 110, (p % 3 == 0) ? 0 : 8, 5,
                      (p == 1) ? 80 : 0);
        end

        drain_polls();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[overcurrent_trip_qualifier_core] OK");
        else
            $display("[overcurrent_trip_qualifier_core] ERROR");
        $finish;
    end

endmodule
